[rtl/core/bif_pkg.sv]
// bif_pkg: shared constants, state encoding and header-scan result type
// for the batched instruction fetch block. No dependencies.
package bif_pkg;

  localparam int WORD_W        = 16;   // program word width
  localparam int CNT_W         = 11;   // program counter / length width
  localparam int RUN_W         = 4;    // run length width
  localparam int BATCH_IDX_W   = 4;    // word index inside a 16-word batch
  localparam int WADDR_W       = 10;   // write address field width
  localparam int DEFAULT_DEPTH = 1024; // program memory depth

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HDR  = 4'b0010,
    ST_ERR  = 4'b0100,
    ST_WORD = 4'b1000
  } bif_state_t;

  // Outcome of decoding one batch header against the counter.
  typedef struct packed {
    logic [CNT_W-1:0] pc_step;  // counter after stepping past the header
    logic [RUN_W-1:0] count;    // words to emit
    logic             trunc;    // run cut short by program end
    logic             none;     // no readable word after stepping
  } bif_plan_t;

endpackage

[rtl/core/bif_ram.sv]
// bif_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module bif_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/bif_hdr_scan.sv]
// bif_hdr_scan: decodes a batch header into the run to emit, bounded by
// the batch end and by the program length. Depends on bif_pkg.
module bif_hdr_scan import bif_pkg::*; (
  input  logic [WORD_W-1:0] header,
  input  logic [CNT_W-1:0]  pc,
  input  logic [CNT_W-1:0]  prog_len,
  output bif_plan_t         plan
);

  logic [BATCH_IDX_W-1:0] sbit;
  logic [CNT_W-1:0]       pcs;
  logic [WORD_W-1:0]      diff;
  logic [BATCH_IDX_W:0]   stop;
  logic [RUN_W-1:0]       run;
  logic [CNT_W-1:0]       avail;

  always_comb begin
    // counter on the header word steps past it
    if (pc[BATCH_IDX_W-1:0] == '0) begin
      pcs  = pc + CNT_W'(1);
      sbit = BATCH_IDX_W'(1);
    end else begin
      pcs  = pc;
      sbit = pc[BATCH_IDX_W-1:0];
    end

    // first bit position above sbit that differs from header[sbit]
    diff = header ^ {WORD_W{header[sbit]}};
    stop = (BATCH_IDX_W+1)'(WORD_W);
    for (int j = WORD_W - 1; j >= 1; j--) begin
      if (((BATCH_IDX_W+1)'(j) > {1'b0, sbit}) && diff[j]) begin
        stop = (BATCH_IDX_W+1)'(j);
      end
    end
    run = RUN_W'(stop - {1'b0, sbit});

    avail        = prog_len - pcs;
    plan.pc_step = pcs;
    plan.none    = !(pcs < prog_len);
    plan.trunc   = avail < CNT_W'(run);
    plan.count   = plan.trunc ? avail[RUN_W-1:0] : run;
  end

endmodule

[rtl/core/batched_instruction_fetch_top.sv]
// batched_instruction_fetch_top: fetch unit for a batched 16-bit program.
// Depends on bif_pkg, bif_ram and bif_hdr_scan.
//
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+-----
//  in      | in_valid, in_stall, in_command,               | in
//          | in_write_address, in_write_data               |
//  out     | out_valid, out_stall, out_word, out_run_length,| out
//          | out_counter_after, out_last, out_error        |
//  cfg     | cfg_wr_en, cfg_wr_data (program_length)        | in
//
// Sequence: a write beat goes to memory when taken. A fetch reads the
// header, decodes it, then emits one word per cycle while the output is
// not stalled, each read through the single read port of the program
// memory; an error beat goes out from ST_ERR. Input is taken only in idle,
// while the last result beat may still wait in the output register.
// Reset: rst_n synchronous, clears counter, program length and control.
// Output stall holds the result register and pauses the word sequencer.
// PROGRAM_DEPTH must be a power of two; addresses wrap modulo the depth.
module batched_instruction_fetch_top import bif_pkg::*; #(
  parameter int PROGRAM_DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // input beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [WADDR_W-1:0] in_write_address,
  input  logic [WORD_W-1:0]  in_write_data,
  // result beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WORD_W-1:0]  out_word,
  output logic [RUN_W-1:0]   out_run_length,
  output logic [CNT_W-1:0]   out_counter_after,
  output logic               out_last,
  output logic               out_error,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data
);

  localparam int AW = $clog2(PROGRAM_DEPTH);

  bif_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] pc_r, pc_nxt;
  logic [CNT_W-1:0] len_r;
  logic [RUN_W-1:0] count_r, count_nxt;
  logic [RUN_W-1:0] idx_r, idx_nxt;
  logic             trunc_r, trunc_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic [RUN_W-1:0]  out_run_r, out_run_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_err_r, out_err_nxt;

  logic              in_acc;
  logic              out_free;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  bif_plan_t         plan;
  logic              word_last;

  // program memory: written by write beats, read for headers and words
  bif_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PROGRAM_DEPTH)
  ) u_prog_mem (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (AW'(in_write_address)),
    .wr_data (in_write_data),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // header decode; header read data is valid in ST_HDR
  bif_hdr_scan u_hdr_scan (
    .header   (ram_rdata),
    .pc       (pc_r),
    .prog_len (len_r),
    .plan     (plan)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign word_last = (RUN_W'(idx_r + RUN_W'(1)) == count_r);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    trunc_nxt = trunc_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = AW'(pc_r);

    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    out_run_nxt   = out_run_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_WRITE) begin
            ram_we = 1'b1;
          end else begin
            // fetch: read batch header
            ram_re    = 1'b1;
            ram_raddr = AW'({pc_r[CNT_W-1:BATCH_IDX_W], {BATCH_IDX_W{1'b0}}});
            state_nxt = ST_HDR;
          end
        end
      end
      ST_HDR: begin
        if (!(pc_r < len_r)) begin
          // counter already out of program: counter unchanged
          state_nxt = ST_ERR;
        end else begin
          pc_nxt    = plan.pc_step;
          count_nxt = plan.count;
          trunc_nxt = plan.trunc;
          idx_nxt   = '0;
          if (plan.none) begin
            state_nxt = ST_ERR;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(plan.pc_step);
            state_nxt = ST_WORD;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          out_run_nxt   = '0;
          out_cnt_nxt   = pc_r;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_WORD: begin
        // ram_rdata holds the word at pc_r until the next read
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = ram_rdata;
          out_run_nxt   = count_r;
          out_cnt_nxt   = pc_r + CNT_W'(1);
          out_last_nxt  = word_last;
          out_err_nxt   = word_last && trunc_r;
          pc_nxt        = pc_r + CNT_W'(1);
          idx_nxt       = RUN_W'(idx_r + RUN_W'(1));
          if (word_last) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(pc_r + CNT_W'(1));
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
    end
  end

  // payload and per-run bookkeeping
  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    idx_r      <= idx_nxt;
    trunc_r    <= trunc_nxt;
    out_word_r <= out_word_nxt;
    out_run_r  <= out_run_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_word          = out_word_r;
  assign out_run_length    = out_run_r;
  assign out_counter_after = out_cnt_r;
  assign out_last          = out_last_r;
  assign out_error         = out_err_r;

  // an error beat always closes its run
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r)
    else $error("error beat without last");

  // a normal word beat never runs past the program end
  a_cnt_in_prog: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_err_r |-> (out_cnt_r <= len_r) && (out_run_r != '0))
    else $error("word beat past program end or empty run");

  // the word sequencer never overruns its count
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WORD |-> idx_r < count_r)
    else $error("word index beyond run count");

  // decode always follows a header read
  a_hdr_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_command == CMD_FETCH |=> state_r == ST_HDR)
    else $error("fetch beat did not start header decode");

endmodule

[tb/batched_instruction_fetch_top_tb.sv]
// Self-checking bench for batched_instruction_fetch_top: program writes,
// run fetches and program_length settings, checked against an in-bench model.
// Depends on bif_pkg and the RTL of batched_instruction_fetch_top.
`timescale 1ns / 100ps

module batched_instruction_fetch_top_tb import bif_pkg::*; ();

  localparam int SETTLE_CYCLES = 24;   // covers a write beat or a full fetch
  localparam int QUIET_LIMIT   = 2000; // cycles with no beat on either side
  localparam int STIM_BEATS    = 450;
  localparam int QUIET_FROM    = 380;  // no gaps or stalls after this beat
  localparam int ROWS          = 20;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [RUN_W-1:0]  run;
    logic [CNT_W-1:0]  cnt;
    logic              last;
    logic              err;
  } fetch_result_t;

  // What one fetch will do from the current counter.
  typedef struct {
    int oob;      // counter at or past program_length
    int hdr_addr; // batch header address
    int step_pc;  // counter after stepping past the header
    int count;    // words to emit
    int trunc;    // run cut at program end
    int none;     // nothing readable after the step
  } fetch_plan_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_FETCH} row_op_t;

  typedef struct {
    row_op_t       op;
    int            arg;   // length for ROW_CFG, address for ROW_WRITE
    logic [15:0]   data;
    bit            typed; // use the result below instead of the model
    fetch_result_t want;
  } fetch_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_command = CMD_WRITE;
  logic [WADDR_W-1:0] in_write_address = '0;
  logic [WORD_W-1:0]  in_write_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [WORD_W-1:0]  out_word;
  logic [RUN_W-1:0]   out_run_length;
  logic [CNT_W-1:0]   out_counter_after;
  logic               out_last;
  logic               out_error;
  logic               cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]   cfg_wr_data = '0;

  // Model state: program image, which words were loaded, counter, length.
  logic [WORD_W-1:0] code_mem [DEFAULT_DEPTH];
  bit                written [DEFAULT_DEPTH];
  int                fetch_pc = 0;
  int                prog_len = 0;

  fetch_result_t fetch_results_q [$]; // result beats still to come, oldest first
  int            beats_sent = 0;
  int            bad_beats = 0;
  int            quiet_cycles = 0;
  int            stall_left = 0;
  bit            gaps_on = 1'b1;

  batched_instruction_fetch_top #(
    .PROGRAM_DEPTH(DEFAULT_DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_write_address (in_write_address),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word         (out_word),
    .out_run_length   (out_run_length),
    .out_counter_after(out_counter_after),
    .out_last         (out_last),
    .out_error        (out_error),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Header scan: step off the header word, count the run of equal header
  // bits from the counter's bit position up to the batch end, then clip
  // the run at program_length.
  function automatic fetch_plan_t plan_fetch();
    fetch_plan_t p;
    logic [15:0] hdr;
    logic        lead;
    int          b;
    int          span;
    int          avail;
    p = '{default: 0};
    p.oob = (fetch_pc >= prog_len);
    if (p.oob) return p;
    p.hdr_addr = fetch_pc & -16;
    p.step_pc = fetch_pc;
    b = fetch_pc % 16;
    if (b == 0) begin
      p.step_pc++;
      b = 1;
    end
    hdr = code_mem[p.hdr_addr] >> b;
    span = 16 - b;
    lead = hdr[0];
    while (p.count < span && hdr[0] == lead) begin
      p.count++;
      hdr = hdr >> 1;
    end
    avail = (prog_len > p.step_pc) ? prog_len - p.step_pc : 0;
    p.none = (avail == 0);
    p.trunc = (avail < p.count);
    if (p.trunc) p.count = avail;
    return p;
  endfunction

  // Queues the result beats of one fetch, moves the counter, returns how many beats it queued.
  function automatic int predict_fetch();
    fetch_plan_t   p;
    fetch_result_t r;
    int            k;
    p = plan_fetch();
    if (p.oob || p.none) begin
      if (p.none) fetch_pc = p.step_pc;
      r = '{16'h0000, 4'd0, 11'(fetch_pc), 1'b1, 1'b1};
      fetch_results_q.push_back(r);
      return 1;
    end
    for (k = 0; k < p.count; k++) begin
      r.word = code_mem[p.step_pc + k];
      r.run  = 4'(p.count);
      r.cnt  = 11'(p.step_pc + k + 1);
      r.last = (k == p.count - 1);
      r.err  = (k == p.count - 1) && (p.trunc != 0);
      fetch_results_q.push_back(r);
    end
    fetch_pc = p.step_pc + p.count;
    return p.count;
  endfunction

  // First program word that the next fetch would read but was never loaded.
  function automatic int first_unwritten();
    fetch_plan_t p;
    int          a;
    if (fetch_pc >= prog_len) return -1;
    a = fetch_pc & -16;
    if (!written[a]) return a;
    p = plan_fetch();
    if (p.none == 0) begin
      for (a = p.step_pc; a < p.step_pc + p.count; a++) begin
        if (!written[a]) return a;
      end
    end
    return -1;
  endfunction

  // Presents one input beat, holds it until taken, then updates the model.
  task automatic put_beat(input logic cmd, input logic [WADDR_W-1:0] addr,
                          input logic [WORD_W-1:0] data, input bit typed = 1'b0,
                          input fetch_result_t want = '0);
    int n;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_write_address <= addr;
    in_write_data    <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (cmd == CMD_WRITE) begin
      code_mem[addr] = data;
      written[addr] = 1'b1;
    end else begin
      n = predict_fetch();
      // rows with a hand-written result replace what the model queued
      if (typed) begin
        repeat (n) void'(fetch_results_q.pop_back());
        fetch_results_q.push_back(want);
      end
    end
  endtask

  // program_length is only written with the block idle: all results back,
  // then a pause for a trailing write beat to finish.
  task automatic load_length(input int len);
    in_valid <= 1'b0;
    while (fetch_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 11'(len);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    prog_len = len;
  endtask

  // Well-formed fetch: first load the header and every word the run will
  // read, then the fetch itself. Headers favor long runs now and then.
  task automatic issue_fetch();
    int          gap;
    logic [15:0] w;
    gap = first_unwritten();
    while (gap >= 0) begin
      w = 16'($urandom);
      if (gap % 16 == 0) begin
        case ($urandom_range(0, 3))
          0: w = 16'h0000;
          1: w = 16'hFFFF;
          2: w = (16'hFFFF << $urandom_range(1, 15)) ^ {16{w[0]}};
          default: ;
        endcase
      end
      put_beat(CMD_WRITE, 10'(gap), w);
      gap = first_unwritten();
    end
    put_beat(CMD_FETCH, 10'($urandom), 16'($urandom));
  endtask

  // Directed rows. Results are typed in only for the error beats; the
  // rest go through the model.
  fetch_row_t script [ROWS] = '{
    // length 0 after reset: counter out of program
    '{ROW_FETCH, 0,    16'h0000, 1'b1, '{16'h0000, 4'd0, 11'd0, 1'b1, 1'b1}},
    '{ROW_CFG,   1,    16'h0000, 1'b0, '0},
    '{ROW_WRITE, 0,    16'h0000, 1'b0, '0},
    // header is the only word: step past it, nothing left to read
    '{ROW_FETCH, 0,    16'h0000, 1'b1, '{16'h0000, 4'd0, 11'd1, 1'b1, 1'b1}},
    '{ROW_CFG,   0,    16'h0000, 1'b0, '0},
    '{ROW_FETCH, 0,    16'h0000, 1'b1, '{16'h0000, 4'd0, 11'd1, 1'b1, 1'b1}},
    '{ROW_CFG,   1024, 16'h0000, 1'b0, '0},
    // header 0xFFF6: runs of 2 and 1 from bit 1, then twelve ones
    '{ROW_WRITE, 0,    16'hFFF6, 1'b0, '0},
    '{ROW_WRITE, 1,    16'hFFFF, 1'b0, '0},
    '{ROW_WRITE, 2,    16'h0000, 1'b0, '0},
    '{ROW_WRITE, 3,    16'h8001, 1'b0, '0},
    '{ROW_FETCH, 0,    16'h0000, 1'b0, '0},
    '{ROW_FETCH, 0,    16'h0000, 1'b0, '0},
    // twelve-word run cut to two at program end
    '{ROW_CFG,   6,    16'h0000, 1'b0, '0},
    '{ROW_WRITE, 4,    16'h1234, 1'b0, '0},
    '{ROW_WRITE, 5,    16'hEDCB, 1'b0, '0},
    '{ROW_FETCH, 0,    16'h0000, 1'b0, '0},
    '{ROW_FETCH, 0,    16'h0000, 1'b1, '{16'h0000, 4'd0, 11'd6, 1'b1, 1'b1}},
    '{ROW_WRITE, 1023, 16'h5A5A, 1'b0, '0},
    '{ROW_WRITE, 682,  16'hA5A5, 1'b0, '0}
  };

  initial begin
    int pick;
    int len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      case (script[i].op)
        ROW_CFG:   load_length(script[i].arg);
        ROW_WRITE: put_beat(CMD_WRITE, 10'(script[i].arg), script[i].data);
        default:   put_beat(CMD_FETCH, 10'(script[i].arg), script[i].data,
                            script[i].typed, script[i].want);
      endcase
    end

    // Random phases: new length, then a burst of fetches with a little
    // write noise mixed in.
    while (beats_sent < STIM_BEATS) begin
      gaps_on = (beats_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 11);
      case (pick)
        0:       len = 0;
        1:       len = 1024;
        2:       len = fetch_pc;                 // every fetch errors
        3:       len = fetch_pc + 1;
        4:       len = (fetch_pc | 15) + 2;      // lands on a bare header
        default: len = fetch_pc + $urandom_range(2, 48);
      endcase
      if (len > 1024) len = 1024;
      load_length(len);
      repeat ($urandom_range(8, 24)) begin
        if ($urandom_range(0, 6) == 0)
          put_beat(CMD_WRITE, 10'($urandom), 16'($urandom));
        else
          issue_fetch();
      end
    end

    in_valid <= 1'b0;
    while (fetch_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_beats == 0)
      $display("[batched_instruction_fetch_top] OK");
    else
      $display("[batched_instruction_fetch_top] ERROR");
    $finish;
  end

  // Result side stalls in bursts while gaps are enabled.
  always @(posedge clk) begin : stall_gen
    int n;
    n = stall_left;
    if (n > 0)
      n--;
    else if (gaps_on && $urandom_range(0, 9) == 0)
      n = $urandom_range(1, 15);
    stall_left = n;
    out_stall <= (n != 0);
  end

  // Every taken result beat is matched against the oldest expected one.
  always @(posedge clk) begin : check_beat
    fetch_result_t seen;
    fetch_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_word, out_run_length, out_counter_after, out_last, out_error};
      if (fetch_results_q.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("unexpected result beat: word %h run %0d cnt %0d last %b err %b",
                   seen.word, seen.run, seen.cnt, seen.last, seen.err);
      end else begin
        want = fetch_results_q.pop_front();
        if (seen !== want) begin
          bad_beats++;
          if (bad_beats <= 10) begin
            $write("result mismatch: exp word %h run %0d cnt %0d last %b err %b,",
                   want.word, want.run, want.cnt, want.last, want.err);
            $display(" got word %h run %0d cnt %0d last %b err %b",
                     seen.word, seen.run, seen.cnt, seen.last, seen.err);
          end
        end
      end
    end
  end

  // Watchdog: too long with no beat taken on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[batched_instruction_fetch_top] ERROR");
      $finish;
    end
  end

endmodule
